>>> hdl/per_prefix_token_bucket_limiter_assert.svh
// Assertion macros used by the token bucket limiter checker.
`ifndef PER_PREFIX_TOKEN_BUCKET_LIMITER_ASSERT_SVH
`define PER_PREFIX_TOKEN_BUCKET_LIMITER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTBL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ptbl_pkg.sv
// Shared constants and control types of the token bucket limiter.
`timescale 1ns / 1ps
`default_nettype none

package ptbl_pkg;

  // Table geometry.
  localparam int INDEX_BITS  = 16;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int CNT_W       = INDEX_BITS + 1;

  // Field widths.
  localparam int ADDR_W   = 32;
  localparam int CMD_W    = 2;
  localparam int TOKEN_W  = 8;
  localparam int PREFIX_W = 5;
  localparam int SHIFT_W  = 6;

  localparam logic [PREFIX_W-1:0] PREFIX_RESET = PREFIX_W'(16);
  localparam logic [PREFIX_W-1:0] PREFIX_MAX   = PREFIX_W'(INDEX_BITS);

  localparam logic [TOKEN_W-1:0] TOKEN_FULL = TOKEN_W'(8'h7f);

  // Command codes; the remaining code is a request that changes nothing.
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_COUNT   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_TICK    = CMD_W'(2);

  // Sweep counter end points.
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_DEPTH);

  // Where the table read address comes from.
  typedef enum logic [1:0] {
    RD_INPUT,
    RD_HELD,
    RD_SWEEP
  } rd_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    clear_wr;
    logic    sweep;
    logic    commit;
    logic    cnt_clr;
    rd_src_e rd_src;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_tick;
    logic clear_done;
    logic sweep_done;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/per_prefix_token_bucket_limiter.sv
// Top level of the per-prefix token bucket limiter.
// Acquire and count requests read the bucket memory in the idle state; in the update state a
// granted acquire writes back and the result register is loaded, waiting while a result is stalled.
// A replenish tick walks the whole table, one entry a cycle.
// After reset the table is cleared in a pass over all 2^INDEX_BITS entries (65536 entries at the
// default size); no request is accepted during that pass, configuration writes are.
`timescale 1ns / 1ps
`default_nettype none

module per_prefix_token_bucket_limiter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [ptbl_pkg::PREFIX_W-1:0]       cfg_wr_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ptbl_pkg::CMD_W-1:0]          command_i,
  input  logic [ptbl_pkg::ADDR_W-1:0]         ip_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [ptbl_pkg::TOKEN_W-1:0] tokens_o,
  output logic                                granted_o
);
  import ptbl_pkg::*;

  // The controller sequences one request at a time; the datapath holds the
  // bucket table, the prefix register and the result register.
  ctl_t ctl;
  sts_t sts;

  // A request is accepted only in the idle state. The result register lets the
  // next request start while an earlier result still waits downstream; that
  // request then holds in its final step until the result register frees up.
  ptbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // The tick sweep is a read-modify-write pipeline: entry k is read while
  // entry k-1 is written back, incremented unless it is already full.
  ptbl_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .command_i     (command_i),
    .ip_address_i  (ip_address_i),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .tokens_o      (tokens_o),
    .granted_o     (granted_o)
  );

endmodule

`default_nettype wire

>>> hdl/ptbl_ctrl.sv
// Controller state machine of the token bucket limiter.
`timescale 1ns / 1ps
`default_nettype none

module ptbl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  ptbl_pkg::sts_t sts_i,
  output ptbl_pkg::ctl_t ctl_o
);
  import ptbl_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    ctl_o          = '0;
    ctl_o.rd_src   = RD_HELD;
    in_stall_o     = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.clear_wr = 1'b1;
        if (sts_i.clear_done) begin
          ctl_o.cnt_clr = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        ctl_o.rd_src = RD_INPUT;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = sts_i.in_tick ? ST_SWEEP : ST_UPDATE;
        end
      end
      ST_SWEEP: begin
        ctl_o.sweep  = 1'b1;
        ctl_o.rd_src = RD_SWEEP;
        if (sts_i.sweep_done) begin
          ctl_o.cnt_clr = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_d = ctl_o.commit ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ptbl_datapath.sv
// Datapath of the token bucket limiter: bucket table, index logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module ptbl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [ptbl_pkg::PREFIX_W-1:0]       cfg_wr_data_i,
  input  logic [ptbl_pkg::CMD_W-1:0]          command_i,
  input  logic [ptbl_pkg::ADDR_W-1:0]         ip_address_i,
  input  ptbl_pkg::ctl_t                      ctl_i,
  output ptbl_pkg::sts_t                      sts_o,
  output logic signed [ptbl_pkg::TOKEN_W-1:0] tokens_o,
  output logic                                granted_o
);
  import ptbl_pkg::*;

  logic [TOKEN_W-1:0]    bucket_mem [TABLE_DEPTH];
  logic [TOKEN_W-1:0]    rd_data_q;
  logic [INDEX_BITS-1:0] rd_addr;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [TOKEN_W-1:0]    wr_data;

  logic [PREFIX_W-1:0]   prefix_q, prefix_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cnt_m1;
  logic [INDEX_BITS-1:0] idx_q;
  logic [CMD_W-1:0]      cmd_q;

  logic [PREFIX_W-1:0]   eff_bits;
  logic [SHIFT_W-1:0]    shamt;
  logic [ADDR_W-1:0]     shifted;
  logic [INDEX_BITS-1:0] in_idx;

  logic                  is_acquire;
  logic                  is_count;
  logic                  positive;
  logic                  take;
  logic                  sweep_wr;

  logic signed [TOKEN_W-1:0] tokens_q;
  logic                      granted_q;

  // Bucket index from the leading address bits, width clamped to the table.
  always_comb begin
    eff_bits = (prefix_q > PREFIX_MAX) ? PREFIX_MAX : prefix_q;
    shamt    = SHIFT_W'(ADDR_W) - SHIFT_W'(eff_bits);
    shifted  = ip_address_i >> shamt;
    in_idx   = (eff_bits == '0) ? '0 : shifted[INDEX_BITS-1:0];
  end

  assign is_acquire = (cmd_q == CMD_ACQUIRE);
  assign is_count   = (cmd_q == CMD_COUNT);
  assign positive   = (rd_data_q != '0) && !rd_data_q[TOKEN_W-1];
  assign take       = is_acquire && positive;
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign sweep_wr   = ctl_i.sweep && (cnt_q != '0) && (cnt_q <= CNT_END);

  always_comb begin
    unique case (ctl_i.rd_src)
      RD_INPUT: rd_addr = in_idx;
      RD_SWEEP: rd_addr = cnt_q[INDEX_BITS-1:0];
      default:  rd_addr = idx_q;
    endcase
  end

  // One write port: clearing pass, tick sweep, or the token take.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = rd_data_q - TOKEN_W'(1);
    priority if (ctl_i.clear_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[INDEX_BITS-1:0];
      wr_data = '0;
    end else if (sweep_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_m1[INDEX_BITS-1:0];
      wr_data = (rd_data_q == TOKEN_FULL) ? rd_data_q : rd_data_q + TOKEN_W'(1);
    end else if (ctl_i.commit && take) begin
      wr_en = 1'b1;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bucket_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= bucket_mem[rd_addr];
  end

  always_comb begin
    if (ctl_i.cnt_clr) begin
      cnt_d = '0;
    end else if (ctl_i.clear_wr || ctl_i.sweep) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
  end

  assign prefix_d = cfg_wr_en_i ? cfg_wr_data_i : prefix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      prefix_q <= PREFIX_RESET;
    end else begin
      cnt_q    <= cnt_d;
      prefix_q <= prefix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      idx_q <= in_idx;
      cmd_q <= command_i;
    end
    if (ctl_i.commit) begin
      tokens_q  <= (is_acquire || is_count) ? $signed(rd_data_q) : '0;
      granted_q <= take;
    end
  end

  assign sts_o.in_tick    = (command_i == CMD_TICK);
  assign sts_o.clear_done = (cnt_q == CNT_LAST);
  assign sts_o.sweep_done = (cnt_q == CNT_END);

  assign tokens_o  = tokens_q;
  assign granted_o = granted_q;

endmodule

`default_nettype wire

>>> hdl/ptbl_checker.sv
// Port-level assertion checker of the token bucket limiter and its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "per_prefix_token_bucket_limiter_assert.svh"

module ptbl_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [ptbl_pkg::TOKEN_W-1:0] tokens_o,
  input logic                                granted_o
);

  // A granted acquire always saw a positive bucket.
  `PTBL_ASSERT_SAME(a_grant_positive, out_valid_o && granted_o, !tokens_o[7] && (tokens_o != 0), "grant with a bucket that is not positive")

  // Only one request is worked on at a time.
  `PTBL_ASSERT_NEXT(a_one_at_a_time, in_valid_i && !in_stall_o, in_stall_o, "request accepted while another is in work")

  // A result never appears in the cycle right after its request is accepted.
  `PTBL_ASSERT_NEXT(a_no_early_result, in_valid_i && !in_stall_o && !out_valid_o, !out_valid_o, "result appeared too early")

  // A stalled result holds.
  `PTBL_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i, out_valid_o && $stable(tokens_o) && $stable(granted_o), "stalled result changed")

endmodule

bind per_prefix_token_bucket_limiter ptbl_checker u_checker (.*);

`default_nettype wire
